>>> sv/upd_pkg.sv
// shared types, constants and helper functions of the url percent decoder
package upd_pkg;

  localparam int MAX_SET_CHARS = 4;
  localparam int SET_BITS      = 8 * MAX_SET_CHARS;
  localparam int LEN_BITS      = 16;
  localparam int OUT_LEN_BITS  = 16;
  localparam int CFG_ADDR_BITS = 5;
  localparam int MAX_RESULTS   = 4;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CASE_FOLD = 8'hDF;

  localparam logic [2:0] REG_PLUS_MODE      = 3'd0;
  localparam logic [2:0] REG_FORBID_CHARS   = 3'd1;
  localparam logic [2:0] REG_FORBID_COUNT   = 3'd2;
  localparam logic [2:0] REG_RESERVED_CHARS = 3'd3;
  localparam logic [2:0] REG_RESERVED_COUNT = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ESC  = 2'd1;
  localparam logic [1:0] ST_BAD_PATH = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h41) begin
      t = (c & CASE_FOLD) - 8'h37;
    end else begin
      t = c - 8'h30;
    end
    return t[3:0];
  endfunction

  function automatic logic in_set(input logic [SET_BITS-1:0] set, input logic [2:0] cnt,
                                  input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MAX_SET_CHARS; i++) begin
      if ((4'(i) < {1'b0, cnt}) && (set[8*i +: 8] == b)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> sv/upd_in_if.sv
// input byte channel of the url percent decoder
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> sv/upd_out_if.sv
// result channel of the url percent decoder
interface upd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        run_last;
  logic        done_res;
  logic [1:0]  status;
  logic [15:0] out_length;

  modport source (output valid, output out_byte, output out_valid, output run_last,
                  output done_res, output status, output out_length, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input run_last,
                  input done_res, input status, input out_length, output ready);
endinterface

>>> sv/url_percent_decoder.sv
// top level: url percent decoder with input register, decode logic and result group register
// Escaped url bytes enter on in_ch and are held in an input register; one pass of
// decode logic turns each byte into zero to four results (decoded bytes, a
// reserved escape passed through as three bytes, and the status item on the
// byte marked last), which are loaded together into a result group register and
// leave on out_ch one per cycle while out_ch.ready is high. A byte giving at most one result
// is taken each cycle on the same condition; one giving more holds the group register until
// its last result leaves, the input register waiting behind it. The user must write registers
// through the apb port only while no url is in flight; the block does not enforce this.
module url_percent_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  upd_in_if.sink                           in_ch,
  upd_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [upd_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // configuration
  logic                          plus_r;
  logic [upd_pkg::SET_BITS-1:0]  forbid_r;
  logic [2:0]                    forbid_cnt_r;
  logic [upd_pkg::SET_BITS-1:0]  reserved_r;
  logic [2:0]                    reserved_cnt_r;
  logic [2:0]                    reg_idx;
  logic                          cfg_wr;

  // input register
  logic                          inq_v_r;
  logic [7:0]                    inq_byte_r;
  logic                          inq_last_r;

  // stream state
  upd_pkg::phase_t               phase_r, phase_nxt, ph_step;
  logic [7:0]                    held_r, held_nxt, held_step;
  logic                          bad_esc_r, bad_esc_nxt;
  logic                          bad_path_r, bad_path_nxt;
  logic [upd_pkg::LEN_BITS-1:0]  len_r, len_nxt, len_step;
  logic                          ended_r, ended_nxt;

  // decode results
  logic [3:0][7:0]               dec_bytes;
  logic [2:0]                    dec_n;
  logic [2:0]                    dec_tot;
  logic [1:0]                    dec_status;
  logic [upd_pkg::LEN_BITS:0]    len_sum;

  // result group register
  logic                          grp_v_r, grp_v_nxt;
  logic [1:0]                    grp_idx_r, grp_idx_nxt;
  logic [1:0]                    grp_lastidx_r;
  logic                          grp_done_r;
  logic [3:0][7:0]               grp_bytes_r;
  logic [1:0]                    grp_status_r;
  logic [upd_pkg::OUT_LEN_BITS-1:0] grp_len_r;

  logic                          out_fire, grp_end, grp_free, adv, is_stat;

  // apb port
  assign pready  = 1'b1;
  assign reg_idx = paddr[upd_pkg::CFG_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      upd_pkg::REG_PLUS_MODE:      prdata = {31'd0, plus_r};
      upd_pkg::REG_FORBID_CHARS:   prdata = forbid_r;
      upd_pkg::REG_FORBID_COUNT:   prdata = {29'd0, forbid_cnt_r};
      upd_pkg::REG_RESERVED_CHARS: prdata = reserved_r;
      upd_pkg::REG_RESERVED_COUNT: prdata = {29'd0, reserved_cnt_r};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_r         <= 1'b0;
      forbid_r       <= '0;
      forbid_cnt_r   <= '0;
      reserved_r     <= '0;
      reserved_cnt_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        upd_pkg::REG_PLUS_MODE:      plus_r         <= pwdata[0];
        upd_pkg::REG_FORBID_CHARS:   forbid_r       <= pwdata;
        upd_pkg::REG_FORBID_COUNT:   forbid_cnt_r   <= pwdata[2:0];
        upd_pkg::REG_RESERVED_CHARS: reserved_r     <= pwdata;
        upd_pkg::REG_RESERVED_COUNT: reserved_cnt_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_fire    = grp_v_r && out_ch.ready;
  assign grp_end     = out_fire && (grp_idx_r == grp_lastidx_r);
  assign grp_free    = !grp_v_r || grp_end;
  assign adv         = inq_v_r && grp_free;
  assign in_ch.ready = !inq_v_r || adv;

  // escape phase after this byte, before the end-of-url clear
  always_comb begin
    ph_step   = phase_r;
    held_step = held_r;
    if (!ended_r) begin
      case (phase_r)
        upd_pkg::PH_IDLE: begin
          ph_step = (inq_byte_r == upd_pkg::CH_PCT) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
        end
        upd_pkg::PH_PCT: begin
          if (upd_pkg::is_hex(inq_byte_r)) begin
            ph_step   = upd_pkg::PH_DIGIT;
            held_step = inq_byte_r;
          end else begin
            ph_step = (inq_byte_r == upd_pkg::CH_PCT) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
          end
        end
        upd_pkg::PH_DIGIT: begin
          ph_step = (!upd_pkg::is_hex(inq_byte_r) && inq_byte_r == upd_pkg::CH_PCT) ?
                    upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
        end
        default: ph_step = upd_pkg::PH_IDLE;
      endcase
    end
    phase_nxt = inq_last_r ? upd_pkg::PH_IDLE : ph_step;
    held_nxt  = inq_last_r ? 8'd0 : held_step;
  end

  // decode of one byte into its results
  always_comb begin
    logic [7:0] b;
    logic [7:0] v;
    logic       do_plain;
    logic       be;
    logic       bp;
    logic       en;
    b         = inq_byte_r;
    v         = {upd_pkg::hex_val(held_r), upd_pkg::hex_val(b)};
    do_plain  = 1'b0;
    be        = bad_esc_r;
    bp        = bad_path_r;
    en        = ended_r;
    dec_bytes = '0;
    dec_n     = '0;
    if (!ended_r) begin
      case (phase_r)
        upd_pkg::PH_IDLE: do_plain = 1'b1;
        upd_pkg::PH_PCT: begin
          if (!upd_pkg::is_hex(b)) begin
            dec_bytes[dec_n[1:0]] = upd_pkg::CH_PCT;
            dec_n    = dec_n + 3'd1;
            be       = 1'b1;
            do_plain = 1'b1;
          end
        end
        upd_pkg::PH_DIGIT: begin
          if (upd_pkg::is_hex(b)) begin
            if (v == 8'd0 || upd_pkg::in_set(forbid_r, forbid_cnt_r, v)) begin
              bp = 1'b1;
              dec_bytes[dec_n[1:0]] = v;
              dec_n = dec_n + 3'd1;
            end else if (upd_pkg::in_set(reserved_r, reserved_cnt_r, v)) begin
              dec_bytes[0] = upd_pkg::CH_PCT;
              dec_bytes[1] = held_r;
              dec_bytes[2] = b;
              dec_n        = 3'd3;
            end else begin
              dec_bytes[dec_n[1:0]] = v;
              dec_n = dec_n + 3'd1;
            end
          end else begin
            dec_bytes[0] = upd_pkg::CH_PCT;
            dec_bytes[1] = held_r;
            dec_n        = 3'd2;
            be           = 1'b1;
            do_plain     = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (do_plain) begin
      if (b == 8'd0) begin
        en = 1'b1;
      end else if (plus_r && b == upd_pkg::CH_PLUS) begin
        dec_bytes[dec_n[1:0]] = upd_pkg::CH_SPACE;
        dec_n = dec_n + 3'd1;
      end else if (b != upd_pkg::CH_PCT) begin
        dec_bytes[dec_n[1:0]] = b;
        dec_n = dec_n + 3'd1;
      end
    end
    // pending escape cut by the end of the url
    if (inq_last_r && !en && ph_step != upd_pkg::PH_IDLE) begin
      be = 1'b1;
      dec_bytes[dec_n[1:0]] = upd_pkg::CH_PCT;
      dec_n = dec_n + 3'd1;
      if (ph_step == upd_pkg::PH_DIGIT) begin
        dec_bytes[dec_n[1:0]] = held_step;
        dec_n = dec_n + 3'd1;
      end
    end
    len_sum    = {1'b0, len_r} + (upd_pkg::LEN_BITS+1)'(dec_n);
    len_step   = (len_sum > {1'b0, upd_pkg::LEN_MAX}) ? upd_pkg::LEN_MAX :
                 len_sum[upd_pkg::LEN_BITS-1:0];
    dec_status = be ? upd_pkg::ST_BAD_ESC : (bp ? upd_pkg::ST_BAD_PATH : upd_pkg::ST_OK);
    dec_tot    = dec_n + {2'b00, inq_last_r};

    bad_esc_nxt  = inq_last_r ? 1'b0 : be;
    bad_path_nxt = inq_last_r ? 1'b0 : bp;
    ended_nxt    = inq_last_r ? 1'b0 : en;
    len_nxt      = inq_last_r ? upd_pkg::LEN_BITS'(1) : len_step;
  end

  // result group control
  always_comb begin
    grp_v_nxt   = grp_v_r;
    grp_idx_nxt = grp_idx_r;
    if (adv) begin
      grp_v_nxt   = (dec_tot != 3'd0);
      grp_idx_nxt = 2'd0;
    end else if (grp_end) begin
      grp_v_nxt = 1'b0;
    end else if (out_fire) begin
      grp_idx_nxt = grp_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r    <= 1'b0;
      grp_v_r    <= 1'b0;
      grp_idx_r  <= '0;
      phase_r    <= upd_pkg::PH_IDLE;
      held_r     <= '0;
      bad_esc_r  <= 1'b0;
      bad_path_r <= 1'b0;
      len_r      <= upd_pkg::LEN_BITS'(1);
      ended_r    <= 1'b0;
    end else begin
      grp_v_r   <= grp_v_nxt;
      grp_idx_r <= grp_idx_nxt;
      if (in_ch.ready) begin
        inq_v_r <= in_ch.valid;
      end
      if (adv) begin
        phase_r    <= phase_nxt;
        held_r     <= held_nxt;
        bad_esc_r  <= bad_esc_nxt;
        bad_path_r <= bad_path_nxt;
        len_r      <= len_nxt;
        ended_r    <= ended_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      inq_byte_r <= in_ch.in_byte;
      inq_last_r <= in_ch.in_last;
    end
    if (adv && dec_tot != 3'd0) begin
      grp_bytes_r   <= dec_bytes;
      grp_lastidx_r <= 2'(dec_tot - 3'd1);
      grp_done_r    <= inq_last_r;
      grp_status_r  <= dec_status;
      grp_len_r     <= upd_pkg::OUT_LEN_BITS'(len_step);
    end
  end

  // output mux
  assign is_stat           = grp_done_r && (grp_idx_r == grp_lastidx_r);
  assign out_ch.valid      = grp_v_r;
  assign out_ch.out_byte   = is_stat ? 8'd0 : grp_bytes_r[grp_idx_r];
  assign out_ch.out_valid  = !is_stat;
  assign out_ch.run_last   = (grp_idx_r == grp_lastidx_r);
  assign out_ch.done_res   = is_stat;
  assign out_ch.status     = is_stat ? grp_status_r : upd_pkg::ST_OK;
  assign out_ch.out_length = is_stat ? grp_len_r : '0;

  // checks
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    grp_v_r |-> (grp_idx_r <= grp_lastidx_r))
    else $error("result index past end of group");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.done_res) |-> out_ch.run_last)
    else $error("status result not last of its group");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && inq_v_r) |-> adv)
    else $error("input register overwritten");

  a_group_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_v_r && !out_ch.ready) |=> (grp_v_r && $stable(grp_idx_r)))
    else $error("result group moved while stalled");

endmodule
